// ----- hw/rtl/cpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_pkg: shared types, constants and table math for the phase ramp mixer
// Holds the configuration register codes, the queue control struct and the
// constant function that builds one entry of the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package cpm_pkg;

    // Default widths, handed to the top level as parameter defaults.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TABLE_BITS_DEF  = 12;

    // Fixed widths of the phase word, the register index and the Q1.15 trig values.
    localparam int PHASE_BITS     = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int TRIG_BITS      = 16;

    // Entries of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // pi/2 in Q60, used to build the sine table at elaboration.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_START_PHASE = 2'd1,
        CFG_ROTATE_POS  = 2'd2
    } cfg_idx_t;

    // Quadrant taken from the top two bits of the table index.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Per-sample control that travels with the sample through the queue.
    typedef struct packed {
        quad_t quad;
        logic  rotate_pos;
    } cpm_ctrl_t;

    // Phase state and registers of the front, visible to the top level.
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_acc;
        logic [PHASE_BITS-1:0] phase_step;
        logic [PHASE_BITS-1:0] start_phase;
    } cpm_status_t;

    // (a * b) >> 60 on 64-bit unsigned values.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // One quarter-wave entry: round(32767 * sin(pi/2 * k / 2^(tbits-2))),
    // from a fixed-point Taylor series in Q60.
    function automatic logic [TRIG_BITS-2:0] sin_entry(input int unsigned k,
                                                       input int unsigned tbits);
        logic [63:0]        unit;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        unit = HALF_PI_Q60 >> (tbits - 2);
        x    = unit * 64'(k);
        x2   = mul_q60(x, x);
        sum  = $signed(x);
        term = mul_q60(x, x2) / 64'd6;      sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd20;  sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd42;  sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd72;  sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd110; sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd156; sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd210; sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd272; sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd342; sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd420; sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd506; sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd600; sum = sum + $signed(term);
        term = mul_q60(term, x2) / 64'd702; sum = sum - $signed(term);
        term = mul_q60(term, x2) / 64'd812; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        v = (((64'(sum)) >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TRIG_BITS-2:0];
    endfunction

endpackage

// ----- hw/rtl/cpm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_front: configuration registers and phase accumulator
// Accepts samples, picks the phase for each one, advances the accumulator and
// pushes the sample with its table index and quadrant into the queue.
// ----------------------------------------------------------------------------
module cpm_front
    import cpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + TABLE_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [PHASE_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    input  logic                          first,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [ENTRY_W-1:0]            push_data,
    output cpm_status_t                   status
);

    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0] phase_step_next;
    logic [PHASE_BITS-1:0] start_phase_reg;
    logic [PHASE_BITS-1:0] start_phase_next;
    logic                  rotate_pos_reg;
    logic                  rotate_pos_next;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phi;
    logic [TABLE_BITS-1:0] table_idx;
    cpm_ctrl_t             ctrl;
    logic                  accept;

    // The queue decides when a sample transaction can be taken; configuration writes are always taken.
    assign cfg_ready  = 1'b1;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Phase for this sample: a first-marked sample restarts at the start phase.
    assign phi       = first ? start_phase_reg : phase_acc_reg;
    assign table_idx = phi[PHASE_BITS-1 -: TABLE_BITS];

    always_comb
    begin
        ctrl.quad       = quad_t'(table_idx[TABLE_BITS-1 -: 2]);
        ctrl.rotate_pos = rotate_pos_reg;
    end

    assign push_data = {sample_re, sample_im, table_idx[TABLE_BITS-3:0], ctrl};

    // Register writes and accumulator update.
    always_comb
    begin
        phase_step_next  = phase_step_reg;
        start_phase_next = start_phase_reg;
        rotate_pos_next  = rotate_pos_reg;
        phase_acc_next   = phase_acc_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PHASE_STEP:  phase_step_next  = cfg_data;
                CFG_START_PHASE: start_phase_next = cfg_data;
                CFG_ROTATE_POS:  rotate_pos_next  = cfg_data[0];
                default:         ;
            endcase
        end
        if (accept) begin
            phase_acc_next = phi + phase_step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_step_reg  <= '0;
            start_phase_reg <= '0;
            rotate_pos_reg  <= 1'b1;
            phase_acc_reg   <= '0;
        end else begin
            phase_step_reg  <= phase_step_next;
            start_phase_reg <= start_phase_next;
            rotate_pos_reg  <= rotate_pos_next;
            phase_acc_reg   <= phase_acc_next;
        end
    end

    always_comb
    begin
        status.phase_acc   = phase_acc_reg;
        status.phase_step  = phase_step_reg;
        status.start_phase = start_phase_reg;
    end

endmodule

// ----- hw/rtl/cpm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_queue: short FIFO between the front and the back
// Holds classified samples so that the front and the back stall independently.
// ----------------------------------------------------------------------------
module cpm_queue
    import cpm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/cpm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_back: table lookup, complex multiply, rounding and saturation
// Three stages: sine ROM read at k and Q-k, four products, then sums with
// round-half-up, shift by 15 and saturation into the output register.
// ----------------------------------------------------------------------------
module cpm_back
    import cpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + TABLE_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [ENTRY_W-1:0]            pop_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im,
    output logic                          clipped
);

    localparam int K_W     = TABLE_BITS - 2;
    localparam int ADDR_W  = TABLE_BITS - 1;
    localparam int QUARTER = 1 << K_W;
    localparam int ROM_W   = TRIG_BITS - 1;
    localparam int PROD_W  = SAMPLE_BITS + TRIG_BITS;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = SAMPLE_BITS + 2;
    localparam logic [ADDR_W-1:0]       QUARTER_ADDR = {1'b1, {K_W{1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF   = ACC_W'(1 << (TRIG_BITS - 2));
    localparam logic signed [RND_W-1:0] SAT_MAX = {3'b000, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_MIN = {3'b111, {(SAMPLE_BITS - 1){1'b0}}};

    // Constant quarter-wave sine table.
    logic [ROM_W-1:0] rom_w [QUARTER + 1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = sin_entry(g, TABLE_BITS);
        assign rom_w[g] = ENTRY;
    end

    // Queue entry fields.
    logic signed [SAMPLE_BITS-1:0] q_re;
    logic signed [SAMPLE_BITS-1:0] q_im;
    logic [K_W-1:0]                q_k;
    cpm_ctrl_t                     q_ctrl;
    logic [ADDR_W-1:0]             addr_a;
    logic [ADDR_W-1:0]             addr_b;

    assign {q_re, q_im, q_k, q_ctrl} = pop_data;
    assign addr_a = {1'b0, q_k};
    assign addr_b = QUARTER_ADDR - {1'b0, q_k};

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic en1;
    logic en2;
    logic en3;
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;

    assign en3       = !out_valid_reg || out_ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign pop_ready = en1;

    // Stage 1: ROM read.
    logic signed [SAMPLE_BITS-1:0] re1_reg;
    logic signed [SAMPLE_BITS-1:0] im1_reg;
    cpm_ctrl_t                     ctrl1_reg;
    logic [ROM_W-1:0]              rom_a_reg;
    logic [ROM_W-1:0]              rom_b_reg;

    always_ff @(posedge clk)
    begin
        if (en1) begin
            re1_reg   <= q_re;
            im1_reg   <= q_im;
            ctrl1_reg <= q_ctrl;
            rom_a_reg <= rom_w[addr_a];
            rom_b_reg <= rom_w[addr_b];
        end
    end

    // Cosine and sine by quadrant, sine negated for the negative rotation.
    logic signed [TRIG_BITS-1:0] tab_a;
    logic signed [TRIG_BITS-1:0] tab_b;
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_q;
    logic signed [TRIG_BITS-1:0] sin_v;

    assign tab_a = {1'b0, rom_a_reg};
    assign tab_b = {1'b0, rom_b_reg};

    always_comb
    begin
        unique case (ctrl1_reg.quad)
            QUAD_0:
            begin
                sin_q = tab_a;
                cos_v = tab_b;
            end
            QUAD_1:
            begin
                sin_q = tab_b;
                cos_v = -tab_a;
            end
            QUAD_2:
            begin
                sin_q = -tab_a;
                cos_v = -tab_b;
            end
            QUAD_3:
            begin
                sin_q = -tab_b;
                cos_v = tab_a;
            end
            default:
            begin
                sin_q = '0;
                cos_v = '0;
            end
        endcase
        sin_v = ctrl1_reg.rotate_pos ? sin_q : -sin_q;
    end

    // Stage 2: the four products.
    logic signed [PROD_W-1:0] p_rc_reg;
    logic signed [PROD_W-1:0] p_is_reg;
    logic signed [PROD_W-1:0] p_ic_reg;
    logic signed [PROD_W-1:0] p_rs_reg;

    always_ff @(posedge clk)
    begin
        if (en2) begin
            p_rc_reg <= PROD_W'(re1_reg) * PROD_W'(cos_v);
            p_is_reg <= PROD_W'(im1_reg) * PROD_W'(sin_v);
            p_ic_reg <= PROD_W'(im1_reg) * PROD_W'(cos_v);
            p_rs_reg <= PROD_W'(re1_reg) * PROD_W'(sin_v);
        end
    end

    // Sums, round half up and shift by 15.
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic signed [ACC_W-1:0] rnd_acc_re;
    logic signed [ACC_W-1:0] rnd_acc_im;
    logic signed [RND_W-1:0] rnd_re;
    logic signed [RND_W-1:0] rnd_im;
    logic signed [SAMPLE_BITS-1:0] sat_re;
    logic signed [SAMPLE_BITS-1:0] sat_im;
    logic                          clip_re;
    logic                          clip_im;

    assign acc_re     = ACC_W'(p_rc_reg) - ACC_W'(p_is_reg);
    assign acc_im     = ACC_W'(p_ic_reg) + ACC_W'(p_rs_reg);
    assign rnd_acc_re = acc_re + ROUND_HALF;
    assign rnd_acc_im = acc_im + ROUND_HALF;
    assign rnd_re     = rnd_acc_re[ACC_W-1:TRIG_BITS-1];
    assign rnd_im     = rnd_acc_im[ACC_W-1:TRIG_BITS-1];

    // Saturation to the sample width.
    always_comb
    begin
        clip_re = 1'b1;
        clip_im = 1'b1;
        priority if (rnd_re > SAT_MAX) begin
            sat_re = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (rnd_re < SAT_MIN) begin
            sat_re = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_re  = rnd_re[SAMPLE_BITS-1:0];
            clip_re = 1'b0;
        end
        priority if (rnd_im > SAT_MAX) begin
            sat_im = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (rnd_im < SAT_MIN) begin
            sat_im = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_im  = rnd_im[SAMPLE_BITS-1:0];
            clip_im = 1'b0;
        end
    end

    // Stage 3: output register.
    logic signed [SAMPLE_BITS-1:0] out_re_reg;
    logic signed [SAMPLE_BITS-1:0] out_im_reg;
    logic                          clipped_reg;

    always_ff @(posedge clk)
    begin
        if (en3) begin
            out_re_reg  <= sat_re;
            out_im_reg  <= sat_im;
            clipped_reg <= clip_re || clip_im;
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= pop_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign clipped   = clipped_reg;

endmodule

// ----- hw/rtl/complex_phase_ramp_mixer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_phase_ramp_mixer_top: NCO complex mixer
// Rotates Q1.15 complex samples by a phase ramp from a 32-bit accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one complex sample per transaction;
//   first restarts the phase at start_phase for that sample. Every sample
//   then advances the phase by phase_step.
//   Output channel (out_valid/out_ready): one rotated sample per input, with
//   clipped set when either part saturated.
//   Configuration channel (cfg_valid/cfg_ready): cfg_index 0 is phase_step,
//   1 is start_phase, 2 is rotate_positive; other indexes are ignored. Write
//   only while no sample is in flight. cfg_ready is always high.
//   Path: an accepted sample is written into the input queue, then passes
//   the ROM, multiply and output register stages before out_valid rises.
//   Throughput: one sample per cycle while out_ready stays high.
//   Stalls: a held out_ready freezes the back pipeline; the 4-entry queue
//   and the 3 stages absorb up to 7 samples before in_ready drops.
//   Reset: phase and registers take their reset values (rotate_positive 1),
//   the queue and pipeline empty; the sine ROM is constant, so no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module complex_phase_ramp_mixer_top
    import cpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TABLE_BITS  = TABLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [PHASE_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    input  logic                          first,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im,
    output logic                          clipped
);

    localparam int ENTRY_W = 2 * SAMPLE_BITS + TABLE_BITS + 1;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    cpm_status_t        status;

    // Front: registers, phase accumulator, classification.
    cpm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TABLE_BITS  (TABLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_re  (sample_re),
        .sample_im  (sample_im),
        .first      (first),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .status     (status)
    );

    // Queue between front and back.
    cpm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: lookup, multiply, round and saturate.
    cpm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TABLE_BITS  (TABLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_re    (out_re),
        .out_im    (out_im),
        .clipped   (clipped)
    );

    // A clipped result carries a saturation limit in at least one part.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (out_re == OUT_MAX) || (out_re == OUT_MIN)
                                 || (out_im == OUT_MAX) || (out_im == OUT_MIN))
        else $error("clipped set without a saturated output");

    // A first-marked sample restarts the ramp: next phase is start plus step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && first |=>
            status.phase_acc == $past(status.start_phase) + $past(status.phase_step))
        else $error("phase did not restart from start_phase");

    // The phase only moves when a sample transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=> $stable(status.phase_acc))
        else $error("phase changed without an input transaction");

endmodule
